### design/dmdsc_pkg.sv
// ----------------------------------------------------------------------------
// dmdsc_pkg
// Shared constants, types and codes of the direct-mapped distinct-source cache.
// ----------------------------------------------------------------------------
package dmdsc_pkg;

  localparam int SLOT_COUNT      = 8192;
  localparam int GROUPS_PER_SLOT = 6;
  localparam int KEY_BYTES       = 16;

  localparam int SLOT_BITS  = $clog2(SLOT_COUNT);
  localparam int CNT_W      = $clog2(GROUPS_PER_SLOT + 1);
  localparam int LEN_W      = 5;
  localparam int WORD_W     = 64;
  localparam int TAG_W      = 4 * WORD_W;
  localparam int DIST_W     = 3;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W     = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W     = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic {
    OP_NOTE  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic {
    ACT_NOTE  = 1'b0,
    ACT_QUERY = 1'b1
  } act_t;

  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [WORD_W-1:0] key_low;
    logic [WORD_W-1:0] key_high;
  } entry_t;

  typedef entry_t [GROUPS_PER_SLOT-1:0] entry_row_t;

  typedef struct packed {
    logic             valid;
    logic [TAG_W-1:0] tag;
    logic [CNT_W-1:0] count;
  } slot_t;

  typedef struct packed {
    act_t                 act;
    logic [SLOT_BITS-1:0] idx;
    logic [TAG_W-1:0]     tag;
    entry_t               entry;
  } item_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

endpackage

### design/dmdsc_req_if.sv
// ----------------------------------------------------------------------------
// dmdsc_req_if
// Request channel: one note or query operation per transfer.
// ----------------------------------------------------------------------------
interface dmdsc_req_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [63:0] hash_word0;
  logic [63:0] hash_word1;
  logic [63:0] hash_word2;
  logic [63:0] hash_word3;
  logic [63:0] group_low;
  logic [63:0] group_high;
  logic [4:0]  group_length;

  modport source (
    output valid, opcode, hash_word0, hash_word1, hash_word2, hash_word3,
           group_low, group_high, group_length,
    input  ready
  );

  modport sink (
    input  valid, opcode, hash_word0, hash_word1, hash_word2, hash_word3,
           group_low, group_high, group_length,
    output ready
  );
endinterface

### design/dmdsc_rsp_if.sv
// ----------------------------------------------------------------------------
// dmdsc_rsp_if
// Response channel: one result per operation.
// ----------------------------------------------------------------------------
interface dmdsc_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] distinct_groups;
  logic       added;
  logic       evicted;

  modport source (
    output valid, distinct_groups, added, evicted,
    input  ready
  );

  modport sink (
    input  valid, distinct_groups, added, evicted,
    output ready
  );
endinterface

### design/dmdsc_front.sv
// ----------------------------------------------------------------------------
// dmdsc_front
// Accepts requests, derives slot index, clips length, masks key bytes and
// turns a zero-length note into a plain lookup.
// ----------------------------------------------------------------------------
module dmdsc_front (
  dmdsc_req_if.sink              req,
  input  dmdsc_pkg::back_status_t status,
  input  logic                   q_full,
  output logic                   q_push,
  output dmdsc_pkg::item_t       q_item
);
  import dmdsc_pkg::*;

  logic [LEN_W-1:0]  len_c;
  logic [WORD_W-1:0] key_low;
  logic [WORD_W-1:0] key_high;

  assign req.ready = !q_full && !status.clearing;
  assign q_push    = req.valid && req.ready;

  always_comb begin
    len_c = (req.group_length > LEN_W'(KEY_BYTES)) ? LEN_W'(KEY_BYTES) : req.group_length;
    for (int b = 0; b < 8; b++) begin
      key_low[8*b +: 8]  = (len_c > LEN_W'(b))     ? req.group_low[8*b +: 8]  : 8'h00;
      key_high[8*b +: 8] = (len_c > LEN_W'(b + 8)) ? req.group_high[8*b +: 8] : 8'h00;
    end
  end

  always_comb begin
    q_item.act = (op_t'(req.opcode) == OP_NOTE && len_c != '0) ? ACT_NOTE : ACT_QUERY;
    q_item.idx = req.hash_word0[SLOT_BITS-1:0];
    q_item.tag = {req.hash_word3, req.hash_word2, req.hash_word1, req.hash_word0};
    q_item.entry.len      = len_c;
    q_item.entry.key_low  = key_low;
    q_item.entry.key_high = key_high;
  end

endmodule

### design/dmdsc_queue.sv
// ----------------------------------------------------------------------------
// dmdsc_queue
// Short FIFO of classified operations between front and back.
// ----------------------------------------------------------------------------
module dmdsc_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  dmdsc_pkg::item_t push_item,
  input  logic             pop,
  output dmdsc_pkg::item_t head,
  output logic             empty,
  output logic             full
);
  import dmdsc_pkg::*;

  item_t             store [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign empty = (count == '0);
  assign full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign head  = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      store[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### design/dmdsc_back.sv
// ----------------------------------------------------------------------------
// dmdsc_back
// Holds the slot and entry memories, clears slot valid bits after reset and
// runs one read-modify-write per operation into the response register.
// ----------------------------------------------------------------------------
module dmdsc_back (
  input  logic                    clk,
  input  logic                    rst,
  input  dmdsc_pkg::item_t        head,
  input  logic                    q_empty,
  output logic                    q_pop,
  output dmdsc_pkg::back_status_t status,
  dmdsc_rsp_if.source             rsp
);
  import dmdsc_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR  = 3'b001,
    ST_READ   = 3'b010,
    ST_UPDATE = 3'b100
  } state_t;

  state_t               state;
  state_t               state_next;
  logic [SLOT_BITS-1:0] clr_idx;

  slot_t      slot_mem [SLOT_COUNT];
  entry_row_t ent_mem  [SLOT_COUNT];

  item_t      cur;
  slot_t      slot_rd;
  entry_row_t ent_rd;

  logic             out_free;
  logic             fire;
  logic             hit;
  logic [CNT_W-1:0] cnt;
  logic             found;
  logic             add;
  logic             evict;
  logic [CNT_W-1:0] cnt_next;
  slot_t            slot_wr;
  logic             slot_we;
  entry_row_t       ent_wr;
  logic [CNT_W-1:0] grp_total;

  logic             out_valid;
  logic [DIST_W-1:0] out_dist;
  logic             out_added;
  logic             out_evicted;

  assign status.clearing = (state == ST_CLEAR);
  assign q_pop    = (state == ST_READ) && !q_empty;
  assign out_free = !out_valid || rsp.ready;
  assign fire     = (state == ST_UPDATE) && out_free;

  always_comb begin
    hit   = slot_rd.valid && (slot_rd.tag == cur.tag);
    evict = (cur.act == ACT_NOTE) && !hit;
    cnt   = hit ? slot_rd.count : '0;
    found = 1'b0;
    for (int i = 0; i < GROUPS_PER_SLOT; i++) begin
      if (CNT_W'(i) < cnt && ent_rd[i] == cur.entry) begin
        found = 1'b1;
      end
    end
    add      = (cur.act == ACT_NOTE) && !found && (cnt < CNT_W'(GROUPS_PER_SLOT));
    cnt_next = cnt + CNT_W'(add);
    ent_wr   = ent_rd;
    for (int i = 0; i < GROUPS_PER_SLOT; i++) begin
      if (cnt == CNT_W'(i)) begin
        ent_wr[i] = cur.entry;
      end
    end
    slot_wr.valid = 1'b1;
    slot_wr.tag   = cur.tag;
    slot_wr.count = cnt_next;
    slot_we       = evict || add;
    grp_total     = (hit || cur.act == ACT_NOTE) ? cnt_next : '0;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_idx == SLOT_BITS'(SLOT_COUNT - 1)) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        if (!q_empty) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (out_free) begin
          state_next = ST_READ;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_idx <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_idx <= clr_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_CLEAR) begin
      slot_mem[clr_idx] <= '0;
    end else if (fire && slot_we) begin
      slot_mem[cur.idx] <= slot_wr;
    end
    if (q_pop) begin
      slot_rd <= slot_mem[head.idx];
    end
  end

  always_ff @(posedge clk) begin
    if (fire && add) begin
      ent_mem[cur.idx] <= ent_wr;
    end
    if (q_pop) begin
      ent_rd <= ent_mem[head.idx];
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur <= head;
    end
    if (fire) begin
      out_dist    <= DIST_W'(grp_total);
      out_added   <= add;
      out_evicted <= evict;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.distinct_groups = out_dist;
  assign rsp.added           = out_added;
  assign rsp.evicted         = out_evicted;

endmodule

### design/direct_mapped_distinct_source_cache.sv
// ----------------------------------------------------------------------------
// direct_mapped_distinct_source_cache
// Direct-mapped table keyed by a 256-bit hash that counts distinct group
// keys per hash, up to six per slot.
//
//   channel  dir  payload
//   req      in   opcode, hash_word0..3, group_low, group_high, group_length
//   rsp      out  distinct_groups, added, evicted
//
// In the back end each operation does a slot and entry memory read, then
// compare, write back and load of the response register.
// After reset the slot valid bits are cleared one slot a cycle over all 8192
// slots, with req held not ready.
// A two-entry queue lets req keep accepting while rsp is stalled; a full
// response register holds the back end in its update step.
// ----------------------------------------------------------------------------
module direct_mapped_distinct_source_cache (
  input logic         clk,
  input logic         rst,
  dmdsc_req_if.sink   req,
  dmdsc_rsp_if.source rsp
);
  import dmdsc_pkg::*;

  item_t        q_in;
  item_t        q_head;
  logic         q_push;
  logic         q_pop;
  logic         q_empty;
  logic         q_full;
  back_status_t status;

  dmdsc_front u_front (
    .req    (req),
    .status (status),
    .q_full (q_full),
    .q_push (q_push),
    .q_item (q_in)
  );

  dmdsc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  dmdsc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (q_head),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .status  (status),
    .rsp     (rsp)
  );

endmodule

### tb/sv/distinct_count_checker.sv
// ----------------------------------------------------------------------------
// distinct_count_checker
// Watches the req and rsp channels of the distinct-source cache, keeps its own
// copy of the slot table, predicts each operation's result at the req
// transfer and compares it in order with every rsp transfer.
// ----------------------------------------------------------------------------
module distinct_count_checker (
  input  logic  clk,
  input  logic  rst,
  dmdsc_req_if  req,
  dmdsc_rsp_if  rsp,
  output int    errors,
  output int    pending,
  output int    adds,
  output int    evicts,
  output int    full_drops
);
  timeunit 1ns;
  timeprecision 1ps;

  import dmdsc_pkg::*;

  typedef struct packed {
    logic [DIST_W-1:0] groups;
    logic              added;
    logic              evicted;
  } tally_t;

  logic              slot_live [SLOT_COUNT];
  logic [TAG_W-1:0]  slot_tag  [SLOT_COUNT];
  int unsigned       slot_cnt  [SLOT_COUNT];
  logic [LEN_W-1:0]  grp_len   [SLOT_COUNT][GROUPS_PER_SLOT];
  logic [WORD_W-1:0] grp_lo    [SLOT_COUNT][GROUPS_PER_SLOT];
  logic [WORD_W-1:0] grp_hi    [SLOT_COUNT][GROUPS_PER_SLOT];

  tally_t expected_tallies [$];

  initial begin
    errors     = 0;
    pending    = 0;
    adds       = 0;
    evicts     = 0;
    full_drops = 0;
  end

  function automatic logic [WORD_W-1:0] low_bytes(int n);
    if (n <= 0) return '0;
    if (n >= 8) return '1;
    return (64'd1 << (8 * n)) - 64'd1;
  endfunction

  function automatic tally_t note_or_query(op_t op, logic [TAG_W-1:0] h,
                                           logic [WORD_W-1:0] glo,
                                           logic [WORD_W-1:0] ghi,
                                           logic [LEN_W-1:0] glen);
    int     idx;
    int     n;
    int     cnt;
    bit     hit;
    bit     dup;
    logic [WORD_W-1:0] klo;
    logic [WORD_W-1:0] khi;
    tally_t r;
    idx = int'(h[SLOT_BITS-1:0]);
    hit = slot_live[idx] && (slot_tag[idx] == h);
    r   = '0;
    if (op == OP_NOTE && glen != '0) begin
      n   = (glen > KEY_BYTES) ? KEY_BYTES : int'(glen);
      klo = glo & low_bytes(n);
      khi = ghi & low_bytes(n - 8);
      if (!hit) begin
        slot_live[idx] = 1'b1;
        slot_tag[idx]  = h;
        slot_cnt[idx]  = 0;
        r.evicted      = 1'b1;
        hit            = 1'b1;
      end
      cnt = slot_cnt[idx];
      dup = 1'b0;
      for (int i = 0; i < cnt; i++) begin
        if (grp_len[idx][i] == n && grp_lo[idx][i] == klo && grp_hi[idx][i] == khi)
          dup = 1'b1;
      end
      if (!dup && cnt < GROUPS_PER_SLOT) begin
        grp_len[idx][cnt] = LEN_W'(n);
        grp_lo[idx][cnt]  = klo;
        grp_hi[idx][cnt]  = khi;
        slot_cnt[idx]     = cnt + 1;
        r.added           = 1'b1;
      end else if (!dup) begin
        full_drops++;
      end
    end
    r.groups = hit ? DIST_W'(slot_cnt[idx]) : '0;
    return r;
  endfunction

  always @(posedge clk) begin
    tally_t got;
    tally_t want;
    if (rst) begin
      foreach (slot_live[i]) slot_live[i] = 1'b0;
      expected_tallies.delete();
    end else begin
      if (rsp.valid === 1'b1 && rsp.ready === 1'b1) begin
        got = '{groups: rsp.distinct_groups, added: rsp.added, evicted: rsp.evicted};
        if (expected_tallies.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: unexpected transfer groups=%0d added=%0d evicted=%0d",
                     $realtime, got.groups, got.added, got.evicted);
        end else begin
          want = expected_tallies.pop_front();
          if (got.groups !== want.groups || got.added !== want.added ||
              got.evicted !== want.evicted) begin
            errors++;
            if (errors <= 10)
              $display("%0t: mismatch expected groups=%0d added=%0d evicted=%0d, %s%0d %s%0d %s%0d",
                       $realtime, want.groups, want.added, want.evicted,
                       "got groups=", got.groups, "added=", got.added,
                       "evicted=", got.evicted);
          end
          adds   += int'(got.added === 1'b1);
          evicts += int'(got.evicted === 1'b1);
        end
      end
      if (req.valid === 1'b1 && req.ready === 1'b1)
        expected_tallies.push_back(note_or_query(op_t'(req.opcode),
                                                 {req.hash_word3, req.hash_word2,
                                                  req.hash_word1, req.hash_word0},
                                                 req.group_low, req.group_high,
                                                 req.group_length));
    end
    pending = expected_tallies.size();
  end

endmodule

### tb/sv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Drives note and query operations into the distinct-source cache: a directed
// walk through duplicate keys, overlong and zero lengths, a full slot and tag
// conflicts, then random operations over a small hash pool under several
// idle, stall and back-pressure patterns. The checker judges every result.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dmdsc_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 110;

  logic clk = 1'b0;
  logic rst = 1'b1;

  dmdsc_req_if req_if ();
  dmdsc_rsp_if rsp_if ();

  int errors;
  int pending;
  int adds;
  int evicts;
  int full_drops;

  int send_idle_pct = 0;
  int rsp_stall_pct = 0;
  bit hold_req      = 1'b0;
  int hold_left     = 0;
  int cycle_count   = 0;
  int notes_sent    = 0;
  int queries_sent  = 0;

  logic [TAG_W-1:0] hash_pool [16];
  logic [LEN_W-1:0] key_len   [8];
  logic [127:0]     key_val   [8];

  direct_mapped_distinct_source_cache u_top (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  distinct_count_checker u_chk (
    .clk        (clk),
    .rst        (rst),
    .req        (req_if),
    .rsp        (rsp_if),
    .errors     (errors),
    .pending    (pending),
    .adds       (adds),
    .evicts     (evicts),
    .full_drops (full_drops)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // hold off for a long stretch on request, else stall at random
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_if.ready = 1'b0;
    end else begin
      rsp_if.ready = ($urandom_range(99) >= rsp_stall_pct);
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [127:0] scramble_tail(logic [127:0] k, int len);
    for (int b = 0; b < 16; b++) begin
      if (b >= len) k[8*b +: 8] = 8'($urandom);
    end
    return k;
  endfunction

  task automatic send_op(input op_t op, input logic [TAG_W-1:0] h,
                         input logic [127:0] key, input logic [LEN_W-1:0] len);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk);
    end
    req_if.valid        = 1'b1;
    req_if.opcode       = op;
    req_if.hash_word0   = h[63:0];
    req_if.hash_word1   = h[127:64];
    req_if.hash_word2   = h[191:128];
    req_if.hash_word3   = h[255:192];
    req_if.group_low    = key[63:0];
    req_if.group_high   = key[127:64];
    req_if.group_length = len;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    if (op == OP_NOTE) notes_sent++;
    else queries_sent++;
  endtask

  task automatic send_random();
    logic [TAG_W-1:0] h;
    logic [127:0]     key;
    logic [LEN_W-1:0] len;
    op_t              op;
    int               j;
    int               pick;
    j  = $urandom_range(7);
    op = ($urandom_range(99) < 30) ? OP_QUERY : OP_NOTE;
    if ($urandom_range(99) < 85) h = hash_pool[$urandom_range(15)];
    else h = {rand64(), rand64(), rand64(), rand64()};
    pick = $urandom_range(99);
    if (pick < 65) begin
      len = key_len[j];
      key = scramble_tail(key_val[j], len);
    end else if (pick < 75) begin
      len = LEN_W'($urandom_range(31, 17));
      key = key_val[j];
    end else if (pick < 85) begin
      len = '0;
      key = {rand64(), rand64()};
    end else begin
      len = LEN_W'($urandom_range(16, 1));
      key = {rand64(), rand64()};
    end
    send_op(op, h, key, len);
  endtask

  initial begin
    logic [TAG_W-1:0] ha;
    logic [TAG_W-1:0] hb;
    logic [127:0]     k1;
    req_if.valid        = 1'b0;
    req_if.opcode       = OP_NOTE;
    req_if.hash_word0   = '0;
    req_if.hash_word1   = '0;
    req_if.hash_word2   = '0;
    req_if.hash_word3   = '0;
    req_if.group_low    = '0;
    req_if.group_high   = '0;
    req_if.group_length = '0;
    rsp_if.ready        = 1'b0;

    for (int i = 0; i < 16; i++) begin
      hash_pool[i] = {rand64(), rand64(), rand64(), rand64()};
      if (i == 1 || i == 3) hash_pool[i][SLOT_BITS-1:0] = hash_pool[i-1][SLOT_BITS-1:0];
    end
    hash_pool[15] = hash_pool[14] ^ {64'd1, 192'd0};
    for (int i = 0; i < 8; i++) begin
      key_val[i] = {rand64(), rand64()};
      key_len[i] = LEN_W'($urandom_range(16, 1));
    end
    key_val[1] = key_val[0];
    key_len[0] = 5'd4;
    key_len[1] = 5'd12;
    ha = {rand64(), rand64(), rand64(), rand64()};
    hb = ha ^ {64'h8000_0000_0000_0000, 192'd0};
    k1 = {rand64(), rand64()};

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_op(OP_QUERY, '0, '0, 5'd0);
    send_op(OP_NOTE,  '0, '1, 5'd0);
    send_op(OP_NOTE,  ha, k1, 5'd1);
    send_op(OP_NOTE,  ha, scramble_tail(k1, 1), 5'd1);
    send_op(OP_NOTE,  ha, k1, 5'd2);
    send_op(OP_NOTE,  ha, '1, 5'd16);
    send_op(OP_NOTE,  ha, '1, 5'd31);
    send_op(OP_NOTE,  ha, '1, 5'd17);
    send_op(OP_NOTE,  ha, k1, 5'd9);
    send_op(OP_NOTE,  ha, k1, 5'd8);
    send_op(OP_NOTE,  ha, '0, 5'd16);
    send_op(OP_NOTE,  ha, k1, 5'd16);
    send_op(OP_NOTE,  ha, '1, 5'd16);
    send_op(OP_QUERY, ha, '1, 5'd16);
    send_op(OP_NOTE,  ha, k1, 5'd0);
    send_op(OP_NOTE,  hb, k1, 5'd5);
    send_op(OP_QUERY, ha, '0, 5'd0);
    send_op(OP_QUERY, hb, '0, 5'd0);
    send_op(OP_NOTE,  '1, '1, 5'd16);
    send_op(OP_NOTE,  '0, '0, 5'd1);
    send_op(OP_QUERY, '1, '0, 5'd31);
    send_op(OP_NOTE,  ha, k1, 5'd3);

    for (int p = 0; p < 5; p++) begin
      case (p)
        1: begin
          send_idle_pct = 55;
          rsp_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          rsp_stall_pct = 55;
        end
        3: begin
          send_idle_pct = 9;
          rsp_stall_pct = 9;
        end
        default: begin
          send_idle_pct = 0;
          rsp_stall_pct = 0;
        end
      endcase
      if (p == 4) hold_req = 1'b1;
      repeat (PHASE_ITEMS) send_random();
    end

    @(negedge clk);
    req_if.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    $display("ran %0d notes and %0d queries over a %0d-hash pool plus random hashes",
             notes_sent, queries_sent, 16);
    $display("results: %0d groups added, %0d slots replaced, %0d notes dropped on full slots",
             adds, evicts, full_drops);
    if (errors == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
